[sv/soft_fork_deployment_tracker_defines.svh]
// Assertion macros for the soft fork deployment tracker RTL.
`ifndef SOFT_FORK_DEPLOYMENT_TRACKER_DEFINES_SVH
`define SOFT_FORK_DEPLOYMENT_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFDT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfdt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfdt assertion failed");

`endif

[sv/sfdt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft fork deployment tracker package
// Shared types and constants for the deployment tracker modules.
// ----------------------------------------------------------------------------
package sfdt_pkg;

    localparam int CFG_DATA_W  = 63;
    localparam int CFG_INDEX_W = 3;
    localparam int TIME_W      = 63;
    localparam int VERSION_W   = 32;
    localparam int PLEN_W      = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_LENGTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCK_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_TIME     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TIME   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIGNAL_BIT     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_MASK       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_PATTERN    = 3'd6;

    typedef enum logic [2:0] {
        ST_DEFINED   = 3'd0,
        ST_STARTED   = 3'd1,
        ST_LOCKED_IN = 3'd2,
        ST_ACTIVE    = 3'd3,
        ST_FAILED    = 3'd4
    } t_dep_state;

    typedef struct packed {
        logic [PLEN_W-1:0]    period_length;
        logic [PLEN_W-1:0]    lock_threshold;
        logic [TIME_W-1:0]    start_time;
        logic [TIME_W-1:0]    timeout_time;
        logic [4:0]           signal_bit;
        logic [VERSION_W-1:0] top_mask;
        logic [VERSION_W-1:0] top_pattern;
    } t_cfg;

    typedef struct packed {
        logic signals;
        logic reached_start;
        logic reached_timeout;
    } t_item;

endpackage

[sv/sfdt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft fork deployment tracker front end
// Classifies one block: version signalling and median time against the window.
// ----------------------------------------------------------------------------
module sfdt_front (
    input  sfdt_pkg::t_cfg                       i_cfg,
    input  logic [sfdt_pkg::VERSION_W-1:0]       i_block_version,
    input  logic [sfdt_pkg::TIME_W-1:0]          i_median_time,
    output sfdt_pkg::t_item                      o_item
);

    logic w_top_match;

    assign w_top_match = ((i_block_version & i_cfg.top_mask) == i_cfg.top_pattern);

    always_comb begin
        o_item.signals         = w_top_match && i_block_version[i_cfg.signal_bit];
        o_item.reached_start   = (i_median_time >= i_cfg.start_time);
        o_item.reached_timeout = (i_median_time >= i_cfg.timeout_time);
    end

endmodule

[sv/sfdt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft fork deployment tracker queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module sfdt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sfdt_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output sfdt_pkg::t_item o_item,
    input  logic            i_pop
);

    localparam int PTR_W = $clog2(sfdt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sfdt_pkg::QUEUE_DEPTH + 1);

    sfdt_pkg::t_item    r_mem [sfdt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               w_push;
    logic               w_pop;

    assign o_ready = (r_count != CNT_W'(sfdt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(sfdt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(sfdt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[sv/sfdt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft fork deployment tracker back end
// Counts signalling blocks, closes periods and advances the deployment state.
// ----------------------------------------------------------------------------
module sfdt_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfdt_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    input  sfdt_pkg::t_item               i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_next_state,
    output logic                          o_block_signals,
    output logic                          o_period_closed
);

    localparam int CMP_W = (COUNT_BITS > sfdt_pkg::PLEN_W) ? COUNT_BITS : sfdt_pkg::PLEN_W;

    sfdt_pkg::t_dep_state             r_state;
    sfdt_pkg::t_dep_state             n_state;
    sfdt_pkg::t_dep_state             w_advanced;
    logic [sfdt_pkg::PLEN_W-1:0]      r_position;
    logic [sfdt_pkg::PLEN_W-1:0]      n_position;
    logic [COUNT_BITS-1:0]            r_count;
    logic [COUNT_BITS-1:0]            n_count;
    logic [COUNT_BITS-1:0]            w_count_inc;
    logic [sfdt_pkg::PLEN_W-1:0]      w_last_position;
    logic                             w_closed;
    logic                             w_locks;
    logic                             r_out_valid;
    logic                             n_out_valid;
    logic [2:0]                       r_out_state;
    logic                             r_out_signals;
    logic                             r_out_closed;

    assign o_pop           = i_valid && (!r_out_valid || i_ready);
    assign o_valid         = r_out_valid;
    assign o_next_state    = r_out_state;
    assign o_block_signals = r_out_signals;
    assign o_period_closed = r_out_closed;

    assign w_count_inc = (i_item.signals && (r_count != '1)) ? r_count + 1'b1 : r_count;
    assign w_last_position = (i_cfg.period_length == '0) ? '0 : i_cfg.period_length - 1'b1;
    assign w_closed = (r_position >= w_last_position);
    assign w_locks  = (CMP_W'(w_count_inc) >= CMP_W'(i_cfg.lock_threshold));

    always_comb begin
        case (r_state)
            sfdt_pkg::ST_DEFINED: begin
                if (i_item.reached_timeout) begin
                    w_advanced = sfdt_pkg::ST_FAILED;
                end else if (i_item.reached_start) begin
                    w_advanced = sfdt_pkg::ST_STARTED;
                end else begin
                    w_advanced = sfdt_pkg::ST_DEFINED;
                end
            end
            sfdt_pkg::ST_STARTED: begin
                if (i_item.reached_timeout) begin
                    w_advanced = sfdt_pkg::ST_FAILED;
                end else if (w_locks) begin
                    w_advanced = sfdt_pkg::ST_LOCKED_IN;
                end else begin
                    w_advanced = sfdt_pkg::ST_STARTED;
                end
            end
            sfdt_pkg::ST_LOCKED_IN: w_advanced = sfdt_pkg::ST_ACTIVE;
            sfdt_pkg::ST_ACTIVE:    w_advanced = sfdt_pkg::ST_ACTIVE;
            default:                w_advanced = sfdt_pkg::ST_FAILED;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_position  = r_position;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_ready;
        if (o_pop) begin
            n_out_valid = 1'b1;
            if (w_closed) begin
                n_state    = w_advanced;
                n_position = '0;
                n_count    = '0;
            end else begin
                n_position = r_position + 1'b1;
                n_count    = w_count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfdt_pkg::ST_DEFINED;
            r_position  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_position  <= n_position;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_state   <= n_state;
            r_out_signals <= i_item.signals;
            r_out_closed  <= w_closed;
        end
    end

endmodule

[sv/soft_fork_deployment_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft fork deployment tracker
// Follows one version-bits deployment over a chain fed block by block.
// ----------------------------------------------------------------------------
// Blocks arrive in height order from genesis on the input channel, one per
// transfer, each with its version word and median time past. Every block gives
// one result on the output channel: the deployment state for the next block,
// whether this block signalled, and whether it closed a signalling period.
// The seven configuration registers are written through the plain write port;
// the user must write them only while the block is idle, which the block does
// not enforce. A block is classified in the cycle it is accepted and pushed
// into a two-entry queue; the back end takes it from the queue into the output
// register. One block is accepted in every cycle while the receiver keeps up;
// the rate is set by the back end updating the period counter and state for
// each block it takes. When the receiver stalls, the result waits in the
// output register, the queue fills with up to two blocks behind it, and input
// ready then stays low until the back end takes an entry. Reset clears the
// state to defined, the period position and the signal count to zero, the
// queue to empty and the registers to their defaults.
// ----------------------------------------------------------------------------
`include "soft_fork_deployment_tracker_defines.svh"

module soft_fork_deployment_tracker #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [sfdt_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [sfdt_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [sfdt_pkg::VERSION_W-1:0]        i_block_version,
    input  logic [sfdt_pkg::TIME_W-1:0]           i_median_time,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [2:0]                            o_next_state,
    output logic                                  o_block_signals,
    output logic                                  o_period_closed
);

    sfdt_pkg::t_cfg  r_cfg;
    sfdt_pkg::t_item w_front_item;
    sfdt_pkg::t_item w_queue_item;
    logic            w_queue_valid;
    logic            w_pop;
    logic            w_out_xfer;
    logic            w_out_active;
    logic            w_out_failed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_length  <= 16'd2016;
            r_cfg.lock_threshold <= 16'd1916;
            r_cfg.start_time     <= '0;
            r_cfg.timeout_time   <= '1;
            r_cfg.signal_bit     <= '0;
            r_cfg.top_mask       <= 32'hE000_0000;
            r_cfg.top_pattern    <= 32'h2000_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfdt_pkg::CFG_PERIOD_LENGTH:  r_cfg.period_length  <= i_cfg_data[15:0];
                sfdt_pkg::CFG_LOCK_THRESHOLD: r_cfg.lock_threshold <= i_cfg_data[15:0];
                sfdt_pkg::CFG_START_TIME:     r_cfg.start_time     <= i_cfg_data;
                sfdt_pkg::CFG_TIMEOUT_TIME:   r_cfg.timeout_time   <= i_cfg_data;
                sfdt_pkg::CFG_SIGNAL_BIT:     r_cfg.signal_bit     <= i_cfg_data[4:0];
                sfdt_pkg::CFG_TOP_MASK:       r_cfg.top_mask       <= i_cfg_data[31:0];
                sfdt_pkg::CFG_TOP_PATTERN:    r_cfg.top_pattern    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    sfdt_front u_front (
        .i_cfg           (r_cfg),
        .i_block_version (i_block_version),
        .i_median_time   (i_median_time),
        .o_item          (w_front_item)
    );

    sfdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_item  (w_front_item),
        .o_ready (o_in_ready),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item),
        .i_pop   (w_pop)
    );

    sfdt_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (w_queue_valid),
        .i_item          (w_queue_item),
        .o_pop           (w_pop),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_next_state    (o_next_state),
        .o_block_signals (o_block_signals),
        .o_period_closed (o_period_closed)
    );

    assign w_out_xfer   = o_out_valid && i_out_ready;
    assign w_out_active = (o_next_state == sfdt_pkg::ST_ACTIVE);
    assign w_out_failed = (o_next_state == sfdt_pkg::ST_FAILED);

    `SFDT_ASSERT_SAME(a_full_only_when_stalled, i_clk, i_rst_n, !o_in_ready, o_out_valid)
    `SFDT_ASSERT_NEXT(a_active_is_terminal, i_clk, i_rst_n, w_out_xfer && w_out_active, !o_out_valid || w_out_active)
    `SFDT_ASSERT_NEXT(a_failed_is_terminal, i_clk, i_rst_n, w_out_xfer && w_out_failed, !o_out_valid || w_out_failed)

endmodule

[tb/soft_fork_deployment_tracker_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft fork deployment tracker checker
// Watches the configuration port and both block channels, keeps its own copy
// of the deployment state machine, and compares every result transfer with the
// state, signal flag and period flag that the accepted block should give.
// ----------------------------------------------------------------------------
module soft_fork_deployment_tracker_checker #(
    parameter int COUNT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sfdt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sfdt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [sfdt_pkg::VERSION_W-1:0]   i_block_version,
    input  logic [sfdt_pkg::TIME_W-1:0]      i_median_time,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [2:0]                       i_next_state,
    input  logic                             i_block_signals,
    input  logic                             i_period_closed,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_blocks_checked,
    output int                               o_periods_closed,
    output logic [4:0]                       o_states_seen
);

    localparam int PLEN_W    = sfdt_pkg::PLEN_W;
    localparam int TIME_W    = sfdt_pkg::TIME_W;
    localparam int VERSION_W = sfdt_pkg::VERSION_W;

    typedef struct packed {
        sfdt_pkg::t_dep_state next_state;
        logic                 block_signals;
        logic                 period_closed;
    } t_block_result;

    t_block_result           expected_results[$];
    sfdt_pkg::t_cfg          settings;
    sfdt_pkg::t_dep_state    deployment;
    logic [PLEN_W-1:0]       period_pos;
    logic [COUNT_BITS-1:0]   signal_tally;

    function automatic logic version_signals(input logic [VERSION_W-1:0] version);
        return ((version & settings.top_mask) == settings.top_pattern)
            && version[settings.signal_bit];
    endfunction

    function automatic sfdt_pkg::t_dep_state advance_state(input sfdt_pkg::t_dep_state st,
                                                           input logic [TIME_W-1:0] mtp);
        case (st)
            sfdt_pkg::ST_DEFINED: begin
                if (mtp >= settings.timeout_time) return sfdt_pkg::ST_FAILED;
                if (mtp >= settings.start_time) return sfdt_pkg::ST_STARTED;
                return sfdt_pkg::ST_DEFINED;
            end
            sfdt_pkg::ST_STARTED: begin
                if (mtp >= settings.timeout_time) return sfdt_pkg::ST_FAILED;
                if (signal_tally >= settings.lock_threshold) return sfdt_pkg::ST_LOCKED_IN;
                return sfdt_pkg::ST_STARTED;
            end
            sfdt_pkg::ST_LOCKED_IN: return sfdt_pkg::ST_ACTIVE;
            sfdt_pkg::ST_ACTIVE: return sfdt_pkg::ST_ACTIVE;
            default: return sfdt_pkg::ST_FAILED;
        endcase
    endfunction

    task automatic predict_block(input logic [VERSION_W-1:0] version,
                                 input logic [TIME_W-1:0] mtp);
        logic [PLEN_W:0] plen;
        t_block_result   r;
        plen = (settings.period_length == '0) ? 17'd1 : {1'b0, settings.period_length};
        r.block_signals = version_signals(version);
        if (r.block_signals && signal_tally != '1) signal_tally++;
        r.period_closed = ({1'b0, period_pos} >= plen - 17'd1);
        if (r.period_closed) begin
            deployment = advance_state(deployment, mtp);
            period_pos = '0;
            signal_tally = '0;
            o_periods_closed++;
        end else begin
            period_pos = period_pos + 1'b1;
        end
        r.next_state = deployment;
        o_states_seen[deployment] = 1'b1;
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic check_result();
        t_block_result want;
        if (expected_results.size() == 0) begin
            o_fail_count++;
            $display("%0t: result with state %0d arrived with no block outstanding",
                     $time, i_next_state);
        end else begin
            want = expected_results.pop_front();
            o_blocks_checked++;
            if (i_next_state !== want.next_state) begin
                o_fail_count++;
                $display("%0t: next_state expected %0d, got %0d",
                         $time, want.next_state, i_next_state);
            end
            if (i_block_signals !== want.block_signals) begin
                o_fail_count++;
                $display("%0t: block_signals expected %0b, got %0b",
                         $time, want.block_signals, i_block_signals);
            end
            if (i_period_closed !== want.period_closed) begin
                o_fail_count++;
                $display("%0t: period_closed expected %0b, got %0b",
                         $time, want.period_closed, i_period_closed);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_results.delete();
            settings.period_length  = 16'd2016;
            settings.lock_threshold = 16'd1916;
            settings.start_time     = '0;
            settings.timeout_time   = '1;
            settings.signal_bit     = '0;
            settings.top_mask       = 32'hE000_0000;
            settings.top_pattern    = 32'h2000_0000;
            deployment       = sfdt_pkg::ST_DEFINED;
            period_pos       = '0;
            signal_tally     = '0;
            o_fail_count     = 0;
            o_blocks_checked = 0;
            o_periods_closed = 0;
            o_states_seen    = 5'b00001;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sfdt_pkg::CFG_PERIOD_LENGTH:
                        settings.period_length  = i_cfg_data[PLEN_W-1:0];
                    sfdt_pkg::CFG_LOCK_THRESHOLD:
                        settings.lock_threshold = i_cfg_data[PLEN_W-1:0];
                    sfdt_pkg::CFG_START_TIME:
                        settings.start_time     = i_cfg_data[TIME_W-1:0];
                    sfdt_pkg::CFG_TIMEOUT_TIME:
                        settings.timeout_time   = i_cfg_data[TIME_W-1:0];
                    sfdt_pkg::CFG_SIGNAL_BIT:
                        settings.signal_bit     = i_cfg_data[4:0];
                    sfdt_pkg::CFG_TOP_MASK:
                        settings.top_mask       = i_cfg_data[VERSION_W-1:0];
                    sfdt_pkg::CFG_TOP_PATTERN:
                        settings.top_pattern    = i_cfg_data[VERSION_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) predict_block(i_block_version, i_median_time);
        end
        o_pending = expected_results.size();
    end

endmodule

[tb/soft_fork_deployment_tracker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft fork deployment tracker testbench
// Feeds a single chain of blocks through the tracker under changing
// configurations, walks the deployment from defined through started to either
// lock-in and activation or a timeout failure, and leaves checking to the
// checker module.
// ----------------------------------------------------------------------------
module soft_fork_deployment_tracker_tb;

    localparam int CFG_DATA_W  = sfdt_pkg::CFG_DATA_W;
    localparam int CFG_INDEX_W = sfdt_pkg::CFG_INDEX_W;
    localparam int TIME_W      = sfdt_pkg::TIME_W;
    localparam int VERSION_W   = sfdt_pkg::VERSION_W;
    localparam int PLEN_W      = sfdt_pkg::PLEN_W;

    localparam int CYCLE_LIMIT        = 400000;
    localparam int BLOCKS_PER_SETTING = 140;
    localparam int RANDOM_SETTINGS    = 12;
    localparam int HOLD_OFF_CYCLES    = 300;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam logic [TIME_W-1:0]      TIME_MAX         = '1;

    typedef enum int {
        PH_DEFINED,
        PH_STARTING,
        PH_STARTED,
        PH_ENDING,
        PH_SETTLED
    } t_phase;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [VERSION_W-1:0]   block_version;
    logic [TIME_W-1:0]      median_time;
    logic                   out_valid;
    logic                   out_ready;
    logic [2:0]             next_state;
    logic                   block_signals;
    logic                   period_closed;

    int         fail_count;
    int         pending;
    int         blocks_checked;
    int         periods_closed;
    logic [4:0] states_seen;

    int             sender_idle_pct;
    int             receiver_idle_pct;
    int             hold_request;
    int             settings_written;
    sfdt_pkg::t_cfg programmed;

    soft_fork_deployment_tracker i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_block_version (block_version),
        .i_median_time   (median_time),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_next_state    (next_state),
        .o_block_signals (block_signals),
        .o_period_closed (period_closed)
    );

    soft_fork_deployment_tracker_checker i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_block_version  (block_version),
        .i_median_time    (median_time),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_next_state     (next_state),
        .i_block_signals  (block_signals),
        .i_period_closed  (period_closed),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_blocks_checked (blocks_checked),
        .o_periods_closed (periods_closed),
        .o_states_seen    (states_seen)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped at the cycle limit with %0d results outstanding.", pending);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int n;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request != 0) begin
                n = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    function automatic logic [TIME_W-1:0] random_time();
        logic [63:0] t;
        t = {$urandom, $urandom};
        return t[TIME_W-1:0];
    endfunction

    // Never the largest time, so a default timeout cannot fire.
    function automatic logic [TIME_W-1:0] bounded_time();
        logic [TIME_W-1:0] t;
        t = random_time();
        if (t == TIME_MAX) t[0] = 1'b0;
        return t;
    endfunction

    function automatic logic [TIME_W-1:0] extreme_time();
        case ($urandom_range(3))
            0: return '0;
            1: return TIME_MAX;
            default: return random_time();
        endcase
    endfunction

    function automatic logic [VERSION_W-1:0] random_version(input int signal_pct);
        logic [VERSION_W-1:0] v;
        int pick;
        pick = $urandom_range(99);
        v = ($urandom & ~programmed.top_mask) | (programmed.top_pattern & programmed.top_mask);
        v[programmed.signal_bit] = 1'b1;
        if (pick >= signal_pct) begin
            if (pick[0]) v[programmed.signal_bit] = 1'b0;
            else v = $urandom;
        end
        return v;
    endfunction

    task automatic send_block(input logic [VERSION_W-1:0] version,
                              input logic [TIME_W-1:0] mtp);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        block_version <= version;
        median_time   <= mtp;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Bits above the register width carry junk, which the block must drop.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value, input int width);
        logic [CFG_DATA_W-1:0] keep;
        logic [63:0]           junk;
        keep = (63'd1 << width) - 63'd1;
        junk = {$urandom, $urandom};
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= (junk[CFG_DATA_W-1:0] & ~keep) | (value & keep);
        @(posedge clk);
    endtask

    task automatic program_settings();
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        wait_drained();
        write_reg(sfdt_pkg::CFG_PERIOD_LENGTH,
                  CFG_DATA_W'(programmed.period_length), PLEN_W);
        write_reg(sfdt_pkg::CFG_LOCK_THRESHOLD,
                  CFG_DATA_W'(programmed.lock_threshold), PLEN_W);
        write_reg(sfdt_pkg::CFG_START_TIME, programmed.start_time, TIME_W);
        write_reg(sfdt_pkg::CFG_TIMEOUT_TIME, programmed.timeout_time, TIME_W);
        write_reg(sfdt_pkg::CFG_SIGNAL_BIT, CFG_DATA_W'(programmed.signal_bit), 5);
        write_reg(sfdt_pkg::CFG_TOP_MASK, CFG_DATA_W'(programmed.top_mask), VERSION_W);
        write_reg(sfdt_pkg::CFG_TOP_PATTERN, CFG_DATA_W'(programmed.top_pattern), VERSION_W);
        write_reg(CFG_UNUSED_INDEX, junk[CFG_DATA_W-1:0], CFG_DATA_W);
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    task automatic choose_settings(input t_phase phase, input bit lock_ending);
        int eff_len;
        programmed.period_length  = PLEN_W'($urandom_range(0, 20));
        programmed.lock_threshold = PLEN_W'($urandom_range(40, 65535));
        programmed.start_time     = '0;
        programmed.timeout_time   = TIME_MAX;
        programmed.signal_bit     = 5'($urandom_range(0, 31));
        case ($urandom_range(3))
            0: programmed.top_mask = '0;
            1: programmed.top_mask = '1;
            default: programmed.top_mask = $urandom;
        endcase
        programmed.top_pattern = ($urandom_range(7) == 0) ? $urandom
                                                           : ($urandom & programmed.top_mask);
        eff_len = (programmed.period_length == 0) ? 1 : programmed.period_length;
        case (phase)
            PH_DEFINED: programmed.start_time = TIME_MAX;
            PH_STARTING: programmed.start_time = random_time() >> 1;
            PH_ENDING: begin
                programmed.top_pattern &= programmed.top_mask;
                if (lock_ending) begin
                    programmed.lock_threshold = PLEN_W'($urandom_range(0, eff_len / 2));
                end else begin
                    programmed.timeout_time = random_time();
                end
            end
            PH_SETTLED: begin
                case ($urandom_range(7))
                    0: programmed.period_length = 16'd0;
                    1: programmed.period_length = 16'd1;
                    2: programmed.period_length = 16'hFFFF;
                    default: programmed.period_length = PLEN_W'($urandom_range(2, 30));
                endcase
                case ($urandom_range(3))
                    0: programmed.lock_threshold = 16'd0;
                    1: programmed.lock_threshold = 16'hFFFF;
                    default: programmed.lock_threshold = PLEN_W'($urandom_range(0, 65535));
                endcase
                programmed.start_time   = extreme_time();
                programmed.timeout_time = extreme_time();
            end
            default: ;
        endcase
    endtask

    initial begin
        t_phase phase;
        bit     lock_ending;
        int     signal_pct;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        block_version <= '0;
        median_time   <= '0;
        rst_n         <= 1'b0;
        sender_idle_pct   = 10;
        receiver_idle_pct = 62;
        hold_request      = 0;
        settings_written  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Blocks under the reset values, then a zero period that also cuts
        // the running period short, then the high signal bits.
        send_block(32'h2000_0001, '0);
        send_block(32'hFFFF_FFFF, TIME_MAX);
        send_block(32'h0000_0000, '0);
        send_block(32'h2000_0000, 63'd1);

        programmed.period_length  = 16'd0;
        programmed.lock_threshold = 16'hFFFF;
        programmed.start_time     = TIME_MAX;
        programmed.timeout_time   = TIME_MAX;
        programmed.signal_bit     = 5'd31;
        programmed.top_mask       = '0;
        programmed.top_pattern    = '0;
        program_settings();
        send_block(32'h8000_0000, TIME_MAX - 63'd1);
        send_block(32'h7FFF_FFFF, '0);
        send_block(32'hFFFF_FFFF, 63'd1);

        programmed.period_length = 16'd1;
        programmed.signal_bit    = 5'd29;
        programmed.top_mask      = 32'hE000_0000;
        programmed.top_pattern   = 32'h2000_0000;
        program_settings();
        send_block(32'h2000_0000, 63'd5);
        send_block(32'h3FFF_FFFF, 63'd2);
        send_block(32'h6000_0000, 63'd9);

        programmed.period_length = 16'd3;
        programmed.signal_bit    = 5'd30;
        programmed.top_mask      = '1;
        programmed.top_pattern   = 32'h4000_0000;
        program_settings();
        send_block(32'h4000_0000, 63'd7);
        send_block(32'h4000_0001, 63'd3);
        send_block(32'hC000_0000, 63'd1);

        lock_ending = ($urandom_range(1) != 0);
        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            case (s / 4)
                0: begin
                    sender_idle_pct   = 10;
                    receiver_idle_pct = 62;
                end
                1: begin
                    sender_idle_pct   = 62;
                    receiver_idle_pct = 10;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            if (s < 2) phase = PH_DEFINED;
            else if (s == 2) phase = PH_STARTING;
            else if (s < 6) phase = PH_STARTED;
            else if (s == 6) phase = PH_ENDING;
            else phase = PH_SETTLED;
            choose_settings(phase, lock_ending);
            if (s == 8) programmed.period_length = 16'hFFFF;
            if (s == 9) begin
                programmed.lock_threshold = 16'd0;
                programmed.timeout_time   = '0;
            end
            program_settings();
            if (s == 4) hold_request = HOLD_OFF_CYCLES;
            signal_pct = (phase == PH_ENDING && lock_ending) ? 90 : 70;
            for (int n = 0; n < BLOCKS_PER_SETTING; n++) begin
                send_block(random_version(signal_pct),
                           (phase == PH_SETTLED) ? extreme_time() : bounded_time());
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Checked %0d blocks under %0d configurations, %0d of them closing a period.",
                 blocks_checked, settings_written, periods_closed);
        $display("Deployment states reached, failed down to defined: %b", states_seen);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[soft_fork_deployment_tracker.f]
+incdir+sv
sv/sfdt_pkg.sv
sv/sfdt_front.sv
sv/sfdt_queue.sv
sv/sfdt_back.sv
sv/soft_fork_deployment_tracker.sv
tb/soft_fork_deployment_tracker_checker.sv
tb/soft_fork_deployment_tracker_tb.sv
